@@ sv/apq_pkg.sv @@
package apq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_BITS    = 16;
  localparam int PRIO_W      = 4;
  localparam int REQ_W       = 2;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_AGE   = 2'd2,
    REQ_QUERY = 2'd3
  } apq_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_POP,
    ST_AGE,
    ST_TIES,
    ST_EMIT
  } apq_state_t;

  typedef struct packed {
    logic                we;
    logic [IDX_W-1:0]    addr;
    logic [TAG_BITS-1:0] tag;
    logic [PRIO_W-1:0]   prio;
  } apq_wr_t;

  typedef struct packed {
    logic              le;
    logic              eq;
    logic [PRIO_W-1:0] dec;
  } apq_cmp_t;

endpackage

@@ sv/apq_in_if.sv @@
interface apq_in_if;
  import apq_pkg::*;

  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [TAG_BITS-1:0] process_tag;
  logic [PRIO_W-1:0]   priority_in;

  modport source (output valid, output req_type, output process_tag, output priority_in,
                  input ready);
  modport sink   (input valid, input req_type, input process_tag, input priority_in,
                  output ready);
endinterface

@@ sv/apq_out_if.sv @@
interface apq_out_if;
  import apq_pkg::*;

  logic                valid;
  logic                ready;
  logic                push_rejected;
  logic                popped_valid;
  logic [TAG_BITS-1:0] popped_tag;
  logic [PRIO_W-1:0]   popped_priority;
  logic                head_valid;
  logic [TAG_BITS-1:0] head_tag;
  logic [PRIO_W-1:0]   head_priority;
  logic [CNT_W-1:0]    entry_count;
  logic [CNT_W-1:0]    tie_count;

  modport source (output valid, output push_rejected, output popped_valid,
                  output popped_tag, output popped_priority, output head_valid,
                  output head_tag, output head_priority, output entry_count,
                  output tie_count, input ready);
  modport sink   (input valid, input push_rejected, input popped_valid,
                  input popped_tag, input popped_priority, input head_valid,
                  input head_tag, input head_priority, input entry_count,
                  input tie_count, output ready);
endinterface

@@ sv/apq_unit.sv @@
module apq_unit (
  input  logic [apq_pkg::PRIO_W-1:0] a,
  input  logic [apq_pkg::PRIO_W-1:0] b,
  output apq_pkg::apq_cmp_t          res
);
  import apq_pkg::*;

  // shared compare and saturating decrement
  always_comb begin
    res.le  = (a <= b);
    res.eq  = (a == b);
    res.dec = (a == '0) ? a : a - PRIO_W'(1);
  end

endmodule

@@ sv/apq_store.sv @@
module apq_store (
  input  logic                         clk,
  input  apq_pkg::apq_wr_t             wr,
  input  logic [apq_pkg::IDX_W-1:0]    rd_idx,
  output logic [apq_pkg::TAG_BITS-1:0] rd_tag,
  output logic [apq_pkg::PRIO_W-1:0]   rd_prio,
  output logic [apq_pkg::TAG_BITS-1:0] head_tag,
  output logic [apq_pkg::PRIO_W-1:0]   head_prio
);
  import apq_pkg::*;

  logic [TAG_BITS-1:0] tag_r  [QUEUE_DEPTH];
  logic [PRIO_W-1:0]   prio_r [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      tag_r[wr.addr]  <= wr.tag;
      prio_r[wr.addr] <= wr.prio;
    end
  end

  assign rd_tag    = tag_r[rd_idx];
  assign rd_prio   = prio_r[rd_idx];
  assign head_tag  = tag_r[0];
  assign head_prio = prio_r[0];

endmodule

@@ sv/ageing_priority_queue_core.sv @@
// channel   role    transaction payload
// in_ch     sink    req_type, process_tag, priority_in
// out_ch    source  push_rejected, popped_*, head_*, entry_count, tie_count
//
// one entry per cycle through a shared compare / decrement unit:
// push shifts entries down from the tail until the new one fits, pop shifts entries up
// and ages them, age decrements every entry; then each remaining entry is checked for
// a tie with the head, and the result is loaded into the output register
// rst_n clears occupancy, sequencer and output valid; entry storage is not cleared
// in_ch.ready is high only while idle; a stalled result holds in the output register
module ageing_priority_queue_core (
  input logic    clk,
  input logic    rst_n,
  apq_in_if.sink   in_ch,
  apq_out_if.source out_ch
);
  import apq_pkg::*;

  apq_state_t          state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    occ_r, occ_nxt;
  logic [CNT_W-1:0]    ties_r, ties_nxt;
  logic [TAG_BITS-1:0] new_tag_r, new_tag_nxt;
  logic [PRIO_W-1:0]   new_prio_r, new_prio_nxt;
  logic                rej_r, rej_nxt;
  logic                pv_r, pv_nxt;
  logic [TAG_BITS-1:0] ptag_r, ptag_nxt;
  logic [PRIO_W-1:0]   pprio_r, pprio_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                o_rej_r, o_pv_r, o_hv_r;
  logic [TAG_BITS-1:0] o_ptag_r, o_htag_r;
  logic [PRIO_W-1:0]   o_pprio_r, o_hprio_r;
  logic [CNT_W-1:0]    o_cnt_r, o_ties_r;
  logic                load_out;

  apq_wr_t             wr;
  logic [IDX_W-1:0]    rd_idx;
  logic [TAG_BITS-1:0] rd_tag, head_tag;
  logic [PRIO_W-1:0]   rd_prio, head_prio, cmp_b;
  apq_cmp_t            cmp;
  logic [CNT_W-1:0]    idx_ext, idx_inc;
  logic                accept;

  apq_store u_store (
    .clk       (clk),
    .wr        (wr),
    .rd_idx    (rd_idx),
    .rd_tag    (rd_tag),
    .rd_prio   (rd_prio),
    .head_tag  (head_tag),
    .head_prio (head_prio)
  );

  apq_unit u_unit (
    .a   (rd_prio),
    .b   (cmp_b),
    .res (cmp)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign idx_ext     = CNT_W'(idx_r);
  assign idx_inc     = idx_ext + CNT_W'(1);
  assign cmp_b       = (state_r == ST_PUSH) ? new_prio_r : head_prio;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    occ_nxt      = occ_r;
    ties_nxt     = ties_r;
    new_tag_nxt  = new_tag_r;
    new_prio_nxt = new_prio_r;
    rej_nxt      = rej_r;
    pv_nxt       = pv_r;
    ptag_nxt     = ptag_r;
    pprio_nxt    = pprio_r;
    rd_idx       = idx_r;
    wr           = '0;
    load_out     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          new_tag_nxt  = in_ch.process_tag;
          new_prio_nxt = in_ch.priority_in;
          rej_nxt      = 1'b0;
          pv_nxt       = 1'b0;
          ptag_nxt     = '0;
          pprio_nxt    = '0;
          idx_nxt      = '0;
          ties_nxt     = '0;
          state_nxt    = ST_TIES;
          unique case (apq_req_t'(in_ch.req_type))
            REQ_PUSH: begin
              if (occ_r == CNT_W'(QUEUE_DEPTH)) begin
                rej_nxt = 1'b1;
              end else begin
                idx_nxt   = occ_r[IDX_W-1:0];
                state_nxt = ST_PUSH;
              end
            end
            REQ_POP: begin
              if (occ_r != '0) begin
                pv_nxt    = 1'b1;
                ptag_nxt  = head_tag;
                pprio_nxt = head_prio;
                state_nxt = ST_POP;
              end
            end
            REQ_AGE: begin
              if (occ_r != '0) begin
                state_nxt = ST_AGE;
              end
            end
            REQ_QUERY: begin
              state_nxt = ST_TIES;
            end
            default: begin
              state_nxt = ST_TIES;
            end
          endcase
        end
      end
      ST_PUSH: begin
        rd_idx  = idx_r - IDX_W'(1);
        wr.we   = 1'b1;
        wr.addr = idx_r;
        if (idx_r == '0 || cmp.le) begin
          wr.tag    = new_tag_r;
          wr.prio   = new_prio_r;
          occ_nxt   = occ_r + CNT_W'(1);
          idx_nxt   = '0;
          state_nxt = ST_TIES;
        end else begin
          wr.tag  = rd_tag;
          wr.prio = rd_prio;
          idx_nxt = idx_r - IDX_W'(1);
        end
      end
      ST_POP: begin
        rd_idx = idx_r + IDX_W'(1);
        if (idx_inc < occ_r) begin
          wr.we   = 1'b1;
          wr.addr = idx_r;
          wr.tag  = rd_tag;
          wr.prio = cmp.dec;
          idx_nxt = idx_r + IDX_W'(1);
        end else begin
          occ_nxt   = occ_r - CNT_W'(1);
          idx_nxt   = '0;
          state_nxt = ST_TIES;
        end
      end
      ST_AGE: begin
        wr.we   = 1'b1;
        wr.addr = idx_r;
        wr.tag  = rd_tag;
        wr.prio = cmp.dec;
        if (idx_inc >= occ_r) begin
          idx_nxt   = '0;
          state_nxt = ST_TIES;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_TIES: begin
        if (occ_r == '0) begin
          state_nxt = ST_EMIT;
        end else begin
          ties_nxt = ties_r + CNT_W'(cmp.eq);
          if (idx_inc >= occ_r) begin
            state_nxt = ST_EMIT;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    ties_r     <= ties_nxt;
    new_tag_r  <= new_tag_nxt;
    new_prio_r <= new_prio_nxt;
    rej_r      <= rej_nxt;
    pv_r       <= pv_nxt;
    ptag_r     <= ptag_nxt;
    pprio_r    <= pprio_nxt;
    if (load_out) begin
      o_rej_r   <= rej_r;
      o_pv_r    <= pv_r;
      o_ptag_r  <= ptag_r;
      o_pprio_r <= pprio_r;
      o_hv_r    <= (occ_r != '0);
      o_htag_r  <= (occ_r != '0) ? head_tag : '0;
      o_hprio_r <= (occ_r != '0) ? head_prio : '0;
      o_cnt_r   <= occ_r;
      o_ties_r  <= ties_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.push_rejected   = o_rej_r;
  assign out_ch.popped_valid    = o_pv_r;
  assign out_ch.popped_tag      = o_ptag_r;
  assign out_ch.popped_priority = o_pprio_r;
  assign out_ch.head_valid      = o_hv_r;
  assign out_ch.head_tag        = o_htag_r;
  assign out_ch.head_priority   = o_hprio_r;
  assign out_ch.entry_count     = o_cnt_r;
  assign out_ch.tie_count       = o_ties_r;

endmodule

@@ sv/apq_checker.sv @@
module apq_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         popped_valid,
  input logic [apq_pkg::TAG_BITS-1:0] popped_tag,
  input logic [apq_pkg::PRIO_W-1:0]   popped_priority,
  input logic                         head_valid,
  input logic [apq_pkg::TAG_BITS-1:0] head_tag,
  input logic [apq_pkg::PRIO_W-1:0]   head_priority,
  input logic [apq_pkg::CNT_W-1:0]    entry_count,
  input logic [apq_pkg::CNT_W-1:0]    tie_count
);
  import apq_pkg::*;

  // one transaction in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !head_valid |->
      head_tag == '0 && head_priority == '0 && tie_count == '0 && entry_count == '0)
    else $error("empty queue reports a head");

  a_ties_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && head_valid |->
      tie_count != '0 && tie_count <= entry_count
      && entry_count <= CNT_W'(QUEUE_DEPTH))
    else $error("tie count out of range");

  a_no_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !popped_valid |-> popped_tag == '0 && popped_priority == '0)
    else $error("pop fields set without a pop");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(head_tag) && $stable(entry_count)
      && $stable(tie_count) && $stable(popped_tag))
    else $error("stalled result changed");

endmodule

bind ageing_priority_queue_core apq_checker u_apq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .popped_valid    (out_ch.popped_valid),
  .popped_tag      (out_ch.popped_tag),
  .popped_priority (out_ch.popped_priority),
  .head_valid      (out_ch.head_valid),
  .head_tag        (out_ch.head_tag),
  .head_priority   (out_ch.head_priority),
  .entry_count     (out_ch.entry_count),
  .tie_count       (out_ch.tie_count)
);
